### hw/rtl/ipv4_port_blacklist_filter_defines.svh
// Assertion helpers for the checker file.
`ifndef IPV4_PORT_BLACKLIST_FILTER_DEFINES_SVH
`define IPV4_PORT_BLACKLIST_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IPBF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipbf: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define IPBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipbf: next-cycle check failed");

`endif

### hw/rtl/ipbf_pkg.sv
package ipbf_pkg;

  localparam int MAX_RULES_DEF = 16;
  localparam int RULE_W        = 96;

  localparam int ETH_LEN    = 14;
  localparam int IP_MIN_END = 34;
  localparam int TCP_LEN    = 20;
  localparam int UDP_LEN    = 8;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [1:0] VERDICT_ACCEPT = 2'd0;
  localparam logic [1:0] VERDICT_RULE   = 2'd1;
  localparam logic [1:0] VERDICT_TRUNC  = 2'd2;
  localparam logic [1:0] VERDICT_PROTO  = 2'd3;

  localparam logic ACTION_BYTE  = 1'b0;
  localparam logic ACTION_WRITE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [3:0]  entry_index;
    logic [31:0] entry_src_addr;
    logic [31:0] entry_dst_addr;
    logic [15:0] entry_src_port;
    logic [15:0] entry_dst_port;
  } in_item_t;

  typedef struct packed {
    logic        accept;
    logic [1:0]  verdict_code;
    logic [31:0] seen_src_addr;
    logic [31:0] seen_dst_addr;
    logic [15:0] seen_src_port;
    logic [15:0] seen_dst_port;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic take;   // input item accepted this cycle
    logic rd;     // read rule entry at walk index
    logic adv;    // advance walk index
    logic hit;    // mark verdict as matched rule
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;   // last byte parses clean and rules are loaded
    logic hit;         // rule read data matches the frame
    logic last_entry;  // walk index is the final rule
  } stat_t;

endpackage

### hw/rtl/ipv4_port_blacklist_filter.sv
// Channel   Ports                          Moves
// --------  -----------------------------  --------------------------------------
// input     in_valid, in_stall, in_data    frame byte or blacklist entry write
// result    out_valid, out_stall, out_data verdict and parsed fields, one a frame
// config    cfg_wr_en, cfg_wr_data         rule_count register
//
// A frame byte that is not last, and an entry write, leave the block ready: a
// new item is accepted every cycle until a last byte is taken.
// A last byte is parsed as it is taken; then each rule entry compared is read
// and checked (rule RAM with registered read; the walk stops at the first hit);
// then the result sits in the result register, held while out_stall is high.
// Input is stalled from the last byte until its result is taken.
// Reset clears rule_count and the frame state; the rule table is not cleared
// and an entry is undefined until written.
module ipv4_port_blacklist_filter #(
  parameter int MAX_RULES = ipbf_pkg::MAX_RULES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // input items
  input  logic                in_valid,
  output logic                in_stall,
  input  ipbf_pkg::in_item_t  in_data,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output ipbf_pkg::out_item_t out_data,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data
);

  ipbf_pkg::cmd_t  cmd;
  ipbf_pkg::stat_t stat;

  // sequence the parse, the rule walk and the result handoff
  ipbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // hold header fields, rule table and result register
  ipbf_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule

### hw/rtl/ipbf_ram.sv
module ipbf_ram #(
  parameter int WIDTH = ipbf_pkg::RULE_W,
  parameter int DEPTH = ipbf_pkg::MAX_RULES_DEF
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/ipbf_ctrl.sv
module ipbf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ipbf_pkg::in_item_t in_data,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ipbf_pkg::stat_t   stat,
  output ipbf_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   take_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_SEND);
  assign take_last = in_valid && (state_r == ST_IDLE) &&
                     (in_data.action == ipbf_pkg::ACTION_BYTE) && in_data.frame_last;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.take  = in_valid && (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (take_last) begin
          state_nxt = stat.need_walk ? ST_READ : ST_SEND;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (stat.hit) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_SEND;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = stat.last_entry ? ST_SEND : ST_READ;
        end
      end
      ST_SEND: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/ipbf_dp.sv
module ipbf_dp #(
  parameter int MAX_RULES = ipbf_pkg::MAX_RULES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [4:0]          cfg_wr_data,
  input  ipbf_pkg::in_item_t  in_data,
  input  ipbf_pkg::cmd_t      cmd,
  output ipbf_pkg::stat_t     stat,
  output ipbf_pkg::out_item_t out_data
);

  localparam int CW = $clog2(MAX_RULES + 1);
  localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int NW = (CW > 5) ? CW : 5;

  logic [4:0]    rule_count_r;
  logic [15:0]   byte_offset_r;
  logic [3:0]    header_words_r, header_words_nxt;
  logic [7:0]    proto_r, proto_nxt;
  logic [31:0]   src_addr_r, src_addr_nxt;
  logic [31:0]   dst_addr_r, dst_addr_nxt;
  logic [15:0]   sport_r, sport_nxt;
  logic [15:0]   dport_r, dport_nxt;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] num_rules;

  ipbf_pkg::out_item_t out_r, out_nxt;

  logic [7:0]  b;
  logic [15:0] off;
  logic [6:0]  tpos;
  logic [15:0] tpos16;
  logic [16:0] len, tpos17;
  logic [1:0]  verdict;
  logic        shown;
  logic        is_byte, is_write, slot_ok;
  logic [ipbf_pkg::RULE_W-1:0] wr_word, rd_word;

  // clamp rule count to table depth
  always_comb begin
    if (NW'(rule_count_r) > NW'(MAX_RULES)) begin
      num_rules = CW'(MAX_RULES);
    end else begin
      num_rules = CW'(rule_count_r);
    end
  end

  assign b        = in_data.frame_byte;
  assign off      = byte_offset_r;
  assign is_byte  = cmd.take && (in_data.action == ipbf_pkg::ACTION_BYTE);
  assign is_write = cmd.take && (in_data.action == ipbf_pkg::ACTION_WRITE);
  assign slot_ok  = (9'(in_data.entry_index) < 9'(MAX_RULES));

  // field capture; IHL taken at this byte applies to this byte already
  always_comb begin
    header_words_nxt = (off == 16'(ipbf_pkg::ETH_LEN)) ? b[3:0] : header_words_r;
    proto_nxt        = (off == 16'(ipbf_pkg::ETH_LEN + 9)) ? b : proto_r;
    src_addr_nxt     = (off >= 16'd26 && off <= 16'd29) ? {src_addr_r[23:0], b}
                                                        : src_addr_r;
    dst_addr_nxt     = (off >= 16'd30 && off <= 16'd33) ? {dst_addr_r[23:0], b}
                                                        : dst_addr_r;
    tpos   = 7'(ipbf_pkg::ETH_LEN) + {1'b0, header_words_nxt, 2'b00};
    tpos16 = 16'(tpos);
    tpos17 = 17'(tpos);
    sport_nxt = (off == tpos16 || off == tpos16 + 16'd1) ? {sport_r[7:0], b}
                                                         : sport_r;
    dport_nxt = (off == tpos16 + 16'd2 || off == tpos16 + 16'd3)
                ? {dport_r[7:0], b} : dport_r;
    len = {1'b0, off} + 17'd1;
  end

  // length and protocol checks, in order
  always_comb begin
    if (len < 17'(ipbf_pkg::IP_MIN_END) || len < tpos17) begin
      verdict = ipbf_pkg::VERDICT_TRUNC;
    end else if (proto_nxt == ipbf_pkg::PROTO_TCP) begin
      verdict = (len < tpos17 + 17'(ipbf_pkg::TCP_LEN)) ? ipbf_pkg::VERDICT_TRUNC
                                                        : ipbf_pkg::VERDICT_ACCEPT;
    end else if (proto_nxt == ipbf_pkg::PROTO_UDP) begin
      verdict = (len < tpos17 + 17'(ipbf_pkg::UDP_LEN)) ? ipbf_pkg::VERDICT_TRUNC
                                                        : ipbf_pkg::VERDICT_ACCEPT;
    end else begin
      verdict = ipbf_pkg::VERDICT_PROTO;
    end
    shown = (verdict == ipbf_pkg::VERDICT_ACCEPT);
    out_nxt.accept        = shown;
    out_nxt.verdict_code  = verdict;
    out_nxt.seen_src_addr = shown ? src_addr_nxt : '0;
    out_nxt.seen_dst_addr = shown ? dst_addr_nxt : '0;
    out_nxt.seen_src_port = shown ? sport_nxt : '0;
    out_nxt.seen_dst_port = shown ? dport_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r   <= '0;
      byte_offset_r  <= '0;
      header_words_r <= '0;
      proto_r        <= '0;
      src_addr_r     <= '0;
      dst_addr_r     <= '0;
      sport_r        <= '0;
      dport_r        <= '0;
      idx_r          <= '0;
    end else begin
      if (cfg_wr_en) begin
        rule_count_r <= cfg_wr_data;
      end
      if (is_byte) begin
        if (in_data.frame_last) begin
          byte_offset_r  <= '0;
          header_words_r <= '0;
          proto_r        <= '0;
          src_addr_r     <= '0;
          dst_addr_r     <= '0;
          sport_r        <= '0;
          dport_r        <= '0;
          idx_r          <= '0;
        end else begin
          if (byte_offset_r != 16'hFFFF) begin
            byte_offset_r <= byte_offset_r + 16'd1;
          end
          header_words_r <= header_words_nxt;
          proto_r        <= proto_nxt;
          src_addr_r     <= src_addr_nxt;
          dst_addr_r     <= dst_addr_nxt;
          sport_r        <= sport_nxt;
          dport_r        <= dport_nxt;
        end
      end else if (cmd.adv) begin
        idx_r <= idx_r + CW'(1);
      end
    end
  end

  // result register; no reset needed
  always_ff @(posedge clk) begin
    if (is_byte && in_data.frame_last) begin
      out_r <= out_nxt;
    end else if (cmd.hit) begin
      out_r.accept       <= 1'b0;
      out_r.verdict_code <= ipbf_pkg::VERDICT_RULE;
    end
  end

  assign wr_word = {in_data.entry_src_addr, in_data.entry_dst_addr,
                    in_data.entry_src_port, in_data.entry_dst_port};

  ipbf_ram #(
    .WIDTH (ipbf_pkg::RULE_W),
    .DEPTH (MAX_RULES)
  ) u_rules (
    .clk     (clk),
    .wr_en   (is_write && slot_ok),
    .wr_addr (AW'(in_data.entry_index)),
    .wr_data (wr_word),
    .rd_en   (cmd.rd),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_word)
  );

  assign stat.need_walk  = (verdict == ipbf_pkg::VERDICT_ACCEPT) && (num_rules != '0);
  assign stat.hit        = (rd_word == {out_r.seen_src_addr, out_r.seen_dst_addr,
                                        out_r.seen_src_port, out_r.seen_dst_port});
  assign stat.last_entry = ((idx_r + CW'(1)) == num_rules);

  assign out_data = out_r;

endmodule

### hw/rtl/ipbf_checker.sv
`include "ipv4_port_blacklist_filter_defines.svh"

module ipbf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ipbf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input ipbf_pkg::out_item_t out_data
);

  // hold a stalled result
  `IPBF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // accept flag agrees with the verdict
  `IPBF_ASSERT_NOW(a_accept_code, out_valid, out_data.accept == (out_data.verdict_code == ipbf_pkg::VERDICT_ACCEPT))

  // drop parsed fields on truncated or unknown-protocol frames
  `IPBF_ASSERT_NOW(a_zero_seen, out_valid && (out_data.verdict_code == ipbf_pkg::VERDICT_TRUNC || out_data.verdict_code == ipbf_pkg::VERDICT_PROTO), out_data.seen_src_addr == 32'd0 && out_data.seen_dst_addr == 32'd0 && out_data.seen_src_port == 16'd0 && out_data.seen_dst_port == 16'd0)

  // a write or a middle byte leaves the block ready and yields no result
  `IPBF_ASSERT_NEXT(a_no_result, in_valid && !in_stall && (in_data.action == ipbf_pkg::ACTION_WRITE || !in_data.frame_last), !in_stall && !out_valid)

endmodule

bind ipv4_port_blacklist_filter ipbf_checker u_ipbf_checker (.*);

### sim/ipv4_port_blacklist_filter_test.sv
module ipv4_port_blacklist_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 5;
  localparam int RULE_SLOTS  = ipbf_pkg::MAX_RULES_DEF;
  localparam int HOLD_CYCLES = 600;
  // Cycles with no item moving on either channel before the run is called hung.
  localparam int STALL_LIMIT = 5000;
  // A protocol that is neither TCP nor UDP.
  localparam logic [7:0] PROTO_OTHER = 8'd1;

  // Tracks the filter's frame parse and blacklist, and queues the verdict that
  // each last byte should produce.
  class verdict_board;
    logic [4:0]  rule_count = '0;
    logic [15:0] byte_pos   = '0;
    logic [3:0]  ihl        = '0;
    logic [7:0]  proto      = '0;
    logic [31:0] src_addr   = '0;
    logic [31:0] dst_addr   = '0;
    logic [15:0] sport      = '0;
    logic [15:0] dport      = '0;
    logic [31:0] rule_src_addr [RULE_SLOTS];
    logic [31:0] rule_dst_addr [RULE_SLOTS];
    logic [15:0] rule_sport [RULE_SLOTS];
    logic [15:0] rule_dport [RULE_SLOTS];
    ipbf_pkg::out_item_t due_verdicts [$];
    int          errors = 0;

    function void take_item(ipbf_pkg::in_item_t it);
      int                  off;
      int                  tpos;
      int                  len;
      int                  n;
      logic [1:0]          verdict;
      ipbf_pkg::out_item_t res;
      if (it.action == ipbf_pkg::ACTION_WRITE) begin
        rule_src_addr[it.entry_index] = it.entry_src_addr;
        rule_dst_addr[it.entry_index] = it.entry_dst_addr;
        rule_sport[it.entry_index]    = it.entry_src_port;
        rule_dport[it.entry_index]    = it.entry_dst_port;
        return;
      end
      off = int'(byte_pos);
      if (off == ipbf_pkg::ETH_LEN) ihl = it.frame_byte[3:0];
      if (off == ipbf_pkg::ETH_LEN + 9) proto = it.frame_byte;
      if (off >= 26 && off <= 29) src_addr = {src_addr[23:0], it.frame_byte};
      if (off >= 30 && off <= 33) dst_addr = {dst_addr[23:0], it.frame_byte};
      // The new IHL already moves the port window on the byte that carries it.
      tpos = ipbf_pkg::ETH_LEN + 4 * int'(ihl);
      if (off == tpos || off == tpos + 1) sport = {sport[7:0], it.frame_byte};
      if (off == tpos + 2 || off == tpos + 3) dport = {dport[7:0], it.frame_byte};
      if (byte_pos != 16'hFFFF) byte_pos++;
      if (!it.frame_last) return;

      len = off + 1;
      if (len < ipbf_pkg::IP_MIN_END || len < tpos) begin
        verdict = ipbf_pkg::VERDICT_TRUNC;
      end else if (proto == ipbf_pkg::PROTO_TCP) begin
        verdict = (len < tpos + ipbf_pkg::TCP_LEN) ? ipbf_pkg::VERDICT_TRUNC
                                                   : ipbf_pkg::VERDICT_ACCEPT;
      end else if (proto == ipbf_pkg::PROTO_UDP) begin
        verdict = (len < tpos + ipbf_pkg::UDP_LEN) ? ipbf_pkg::VERDICT_TRUNC
                                                   : ipbf_pkg::VERDICT_ACCEPT;
      end else begin
        verdict = ipbf_pkg::VERDICT_PROTO;
      end

      if (verdict == ipbf_pkg::VERDICT_ACCEPT) begin
        n = (int'(rule_count) > RULE_SLOTS) ? RULE_SLOTS : int'(rule_count);
        for (int i = 0; i < n; i++) begin
          if (rule_src_addr[i] == src_addr && rule_dst_addr[i] == dst_addr &&
              rule_sport[i] == sport && rule_dport[i] == dport) begin
            verdict = ipbf_pkg::VERDICT_RULE;
            break;
          end
        end
      end

      res.accept       = (verdict == ipbf_pkg::VERDICT_ACCEPT);
      res.verdict_code = verdict;
      if (verdict == ipbf_pkg::VERDICT_ACCEPT || verdict == ipbf_pkg::VERDICT_RULE) begin
        res.seen_src_addr = src_addr;
        res.seen_dst_addr = dst_addr;
        res.seen_src_port = sport;
        res.seen_dst_port = dport;
      end else begin
        res.seen_src_addr = '0;
        res.seen_dst_addr = '0;
        res.seen_src_port = '0;
        res.seen_dst_port = '0;
      end
      due_verdicts.push_back(res);

      byte_pos = '0;
      ihl      = '0;
      proto    = '0;
      src_addr = '0;
      dst_addr = '0;
      sport    = '0;
      dport    = '0;
    endfunction

    function void match_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_verdict(ipbf_pkg::out_item_t got);
      ipbf_pkg::out_item_t want;
      if (due_verdicts.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected, got %h", $time, got);
        return;
      end
      want = due_verdicts.pop_front();
      match_field("accept", 32'(want.accept), 32'(got.accept));
      match_field("verdict_code", 32'(want.verdict_code), 32'(got.verdict_code));
      match_field("seen_src_addr", want.seen_src_addr, got.seen_src_addr);
      match_field("seen_dst_addr", want.seen_dst_addr, got.seen_dst_addr);
      match_field("seen_src_port", 32'(want.seen_src_port), 32'(got.seen_src_port));
      match_field("seen_dst_port", 32'(want.seen_dst_port), 32'(got.seen_dst_port));
    endfunction
  endclass

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  ipbf_pkg::in_item_t  in_data     = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  ipbf_pkg::out_item_t out_data;
  logic                cfg_wr_en   = 1'b0;
  logic [4:0]          cfg_wr_data = '0;

  verdict_board sb;

  // Pacing: percent of cycles in which the sender idles or the receiver stalls.
  int send_idle_pct  = 33;
  int recv_stall_pct = 77;
  // Bumping hold_orders asks the receiver for one long hold-off.
  int hold_orders    = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int items_taken    = 0;
  int quiet_cycles   = 0;

  always #HALF_PERIOD clk = ~clk;

  ipv4_port_blacklist_filter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Receiver: pick the stall for the next edge at the falling edge. A hold-off
  // order is picked up at a falling edge after it is posted, then counted down here.
  always @(negedge clk) begin
    if (hold_orders != hold_seen) begin
      hold_seen = hold_orders;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check each verdict as it is taken, and watch for a hung channel pair.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_verdict(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("FAIL ipv4_port_blacklist_filter");
          $finish;
        end
      end
    end
  end

  // Fill every field with noise; callers overwrite the ones that matter.
  function automatic ipbf_pkg::in_item_t random_item();
    ipbf_pkg::in_item_t it;
    it.action         = 1'($urandom_range(1));
    it.frame_byte     = 8'($urandom);
    it.frame_last     = 1'($urandom_range(1));
    it.entry_index    = 4'($urandom);
    it.entry_src_addr = $urandom;
    it.entry_dst_addr = $urandom;
    it.entry_src_port = 16'($urandom);
    it.entry_dst_port = 16'($urandom);
    return it;
  endfunction

  // Offer one item after an optional run of idle cycles, and hold it until it
  // is taken. Call and return at a falling edge.
  task automatic send_item(input ipbf_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_item(it);
    items_taken++;
    @(negedge clk);
  endtask

  task automatic send_entry_write(input logic [3:0] idx, input logic [31:0] sa,
                                  input logic [31:0] da, input logic [15:0] sp,
                                  input logic [15:0] dp);
    ipbf_pkg::in_item_t it;
    it                = random_item();
    it.action         = ipbf_pkg::ACTION_WRITE;
    it.entry_index    = idx;
    it.entry_src_addr = sa;
    it.entry_dst_addr = da;
    it.entry_src_port = sp;
    it.entry_dst_port = dp;
    send_item(it);
  endtask

  task automatic send_random_write();
    send_entry_write(4'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom));
  endtask

  // Build a frame byte by byte: Ethernet filler, IPv4 header with the given
  // version, IHL and protocol, addresses, then the ports where they land past
  // the fixed header. Entry writes are slipped in between bytes at write_pct.
  task automatic send_frame(input logic [3:0] ver, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [31:0] sa,
                            input logic [31:0] da, input logic [15:0] sp,
                            input logic [15:0] dp, input int len, input int write_pct);
    ipbf_pkg::in_item_t it;
    int                 tpos;
    logic [7:0]         b;
    tpos = ipbf_pkg::ETH_LEN + 4 * int'(ihl);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < write_pct) send_random_write();
      b = 8'($urandom);
      if (i == ipbf_pkg::ETH_LEN) begin
        b = {ver, ihl};
      end else if (i == ipbf_pkg::ETH_LEN + 9) begin
        b = proto;
      end else if (i >= 26 && i <= 29) begin
        b = sa[8 * (29 - i) +: 8];
      end else if (i >= 30 && i <= 33) begin
        b = da[8 * (33 - i) +: 8];
      end else if (i >= ipbf_pkg::IP_MIN_END && i >= tpos && i < tpos + 2) begin
        b = sp[8 * (tpos + 1 - i) +: 8];
      end else if (i >= ipbf_pkg::IP_MIN_END && i >= tpos + 2 && i < tpos + 4) begin
        b = dp[8 * (tpos + 3 - i) +: 8];
      end
      it            = random_item();
      it.action     = ipbf_pkg::ACTION_BYTE;
      it.frame_byte = b;
      it.frame_last = (i == len - 1);
      send_item(it);
    end
  endtask

  // Plain IPv4 frame whose four tuple copies blacklist slot idx.
  task automatic send_rule_frame(input int idx, input logic [7:0] proto, input int len);
    send_frame(4'd4, 4'd5, proto, sb.rule_src_addr[idx], sb.rule_dst_addr[idx],
               sb.rule_sport[idx], sb.rule_dport[idx], len, 0);
  endtask

  // Frame with a random four tuple.
  task automatic send_noise_frame(input logic [3:0] ver, input logic [3:0] ihl,
                                  input logic [7:0] proto, input int len);
    send_frame(ver, ihl, proto, $urandom, $urandom, 16'($urandom), 16'($urandom),
               len, 0);
  endtask

  // Mostly well-formed TCP/UDP frames, half of them aimed at a blacklist slot
  // (some with one bit off), plus odd IHL and version values, other protocols
  // and cut-short frames.
  task automatic random_frame();
    int          idx;
    int          hdr;
    int          need;
    int          len;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    ihl = ($urandom_range(99) < 80) ? 4'd5 : 4'($urandom_range(15));
    ver = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd4;
    case ($urandom_range(9))
      0:          proto = 8'($urandom_range(255));
      1, 2, 3, 4: proto = ipbf_pkg::PROTO_TCP;
      default:    proto = ipbf_pkg::PROTO_UDP;
    endcase
    hdr  = (proto == ipbf_pkg::PROTO_TCP) ? ipbf_pkg::TCP_LEN : ipbf_pkg::UDP_LEN;
    need = ipbf_pkg::ETH_LEN + 4 * int'(ihl) + hdr;
    if (need < ipbf_pkg::IP_MIN_END) need = ipbf_pkg::IP_MIN_END;
    idx = int'($urandom_range(RULE_SLOTS - 1));
    if ($urandom_range(1)) begin
      sa = sb.rule_src_addr[idx];
      da = sb.rule_dst_addr[idx];
      sp = sb.rule_sport[idx];
      dp = sb.rule_dport[idx];
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       sa ^= 32'd1 << $urandom_range(31);
          1:       da ^= 32'd1 << $urandom_range(31);
          2:       sp ^= 16'd1 << $urandom_range(15);
          default: dp ^= 16'd1 << $urandom_range(15);
        endcase
      end
    end else begin
      sa = $urandom;
      da = $urandom;
      sp = 16'($urandom);
      dp = 16'($urandom);
    end
    if ($urandom_range(99) < 70) len = need + int'($urandom_range(6));
    else len = int'($urandom_range(need - 1, 1));
    send_frame(ver, ihl, proto, sa, da, sp, dp, len, 3);
  endtask

  task automatic random_stretch(input int min_items, input int min_frames);
    int start;
    int frames;
    start  = items_taken;
    frames = 0;
    while (items_taken - start < min_items || frames < min_frames) begin
      if ($urandom_range(9) == 0) send_random_write();
      random_frame();
      frames++;
    end
  endtask

  // Drop valid and hold until every expected verdict has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.due_verdicts.size() != 0);
  endtask

  // Change rule_count only with the filter idle: drain, let the last byte or
  // write settle, then pulse the write enable for one cycle.
  task automatic set_rule_count(input logic [4:0] count);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.rule_count = count;
  endtask

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Load every slot before any frame can walk the table: slot 0 all zero,
    // slot 15 all ones, the rest random.
    send_entry_write(4'd0, '0, '0, '0, '0);
    send_entry_write(4'd15, '1, '1, '1, '1);
    for (int s = 1; s < RULE_SLOTS - 1; s++)
      send_entry_write(4'(s), $urandom, $urandom, 16'($urandom), 16'($urandom));

    // Directed frames, rule_count still at its reset value of zero.
    send_rule_frame(1, ipbf_pkg::PROTO_TCP, 1);     // one-byte frame
    send_rule_frame(1, ipbf_pkg::PROTO_UDP, 33);    // one short of the address bytes
    send_noise_frame(4'd4, 4'd15, ipbf_pkg::PROTO_UDP, 40);
    send_rule_frame(1, ipbf_pkg::PROTO_TCP, 53);    // TCP header one byte short
    send_rule_frame(1, ipbf_pkg::PROTO_TCP, 54);    // matches slot 1, no rules active
    send_rule_frame(2, ipbf_pkg::PROTO_UDP, 41);    // UDP header one byte short
    send_rule_frame(2, ipbf_pkg::PROTO_UDP, 42);
    send_rule_frame(2, PROTO_OTHER, 60);            // neither TCP nor UDP
    // IHL below five: ports overlap the IP header; version nibble ignored.
    send_noise_frame(4'hF, 4'd0, ipbf_pkg::PROTO_UDP, 42);
    send_noise_frame(4'h0, 4'd2, ipbf_pkg::PROTO_TCP, 41);
    send_noise_frame(4'h4, 4'd3, ipbf_pkg::PROTO_TCP, 46);

    // Full table: hit on the last slot, on the first, a miss, and a frame
    // with entry writes slipped between its bytes.
    set_rule_count(5'd16);
    send_rule_frame(15, ipbf_pkg::PROTO_UDP, 42);
    send_rule_frame(0, ipbf_pkg::PROTO_TCP, 54);
    send_noise_frame(4'd4, 4'd5, ipbf_pkg::PROTO_TCP, 60);
    send_frame(4'd4, 4'd5, ipbf_pkg::PROTO_UDP, sb.rule_src_addr[5], sb.rule_dst_addr[5],
               sb.rule_sport[5], sb.rule_dport[5], 50, 20);

    // A count past the table size still walks the whole table.
    set_rule_count(5'd31);
    send_rule_frame(15, ipbf_pkg::PROTO_TCP, 60);

    // Only slot 0 active.
    set_rule_count(5'd1);
    send_rule_frame(0, ipbf_pkg::PROTO_UDP, 42);
    send_rule_frame(15, ipbf_pkg::PROTO_UDP, 42);

    // Random frames, sender idling a third of the time, receiver mostly stalled.
    set_rule_count(5'($urandom_range(16, 1)));
    random_stretch(60, 1);
    set_rule_count(5'd16);
    random_stretch(60, 1);

    // Swap the pacing; hold the receiver off for a long stretch while frames
    // keep coming, and pause the sender once until all verdicts are back.
    send_idle_pct  = 77;
    recv_stall_pct <= 33;
    set_rule_count(5'd0);
    random_stretch(50, 1);
    hold_orders <= hold_orders + 1;
    random_stretch(50, 1);
    wait_drained();
    random_stretch(40, 1);
    set_rule_count(5'd31);
    random_stretch(50, 1);

    // No idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    set_rule_count(5'($urandom_range(31)));
    random_stretch(60, 1);
    random_stretch(40, 1);

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("PASS ipv4_port_blacklist_filter");
    else $display("FAIL ipv4_port_blacklist_filter");
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ipbf_pkg.sv
hw/rtl/ipbf_ram.sv
hw/rtl/ipbf_ctrl.sv
hw/rtl/ipbf_dp.sv
hw/rtl/ipv4_port_blacklist_filter.sv
hw/rtl/ipbf_checker.sv
sim/ipv4_port_blacklist_filter_test.sv
